[rtl/eacd_pkg.sv]
// eacd_pkg: shared types, mode bit positions, command codes and the basic palette
// used by the attribute cell decoder modules; no dependencies

package eacd_pkg;

  typedef logic [5:0] color_t;
  typedef logic [7:0][5:0] pix_row_t;  // element i is pixel i, pixel 0 leftmost

  typedef enum logic [1:0] {
    CMD_PORT_WRITE = 2'd0,
    CMD_CELL       = 2'd1,
    CMD_BORDER     = 2'd2
  } command_t;

  localparam logic [15:0] MODE_PORT_ADDR = 16'h7FDF;

  // mode register bit positions
  localparam int unsigned MODE_HALF    = 7;
  localparam int unsigned MODE_EBORDER = 4;
  localparam int unsigned MODE_DOUBLE  = 3;
  localparam int unsigned MODE_EXTRA   = 2;

  localparam color_t COLOR_BLACK      = 6'd0;
  localparam color_t COLOR_WHITE      = 6'd42;
  localparam color_t COLOR_BRIGHT_WHT = 6'd63;

  // basic colour, bit 3 = bright
  function automatic color_t basic_index(input logic [3:0] c);
    color_t r;
    case (c)
      4'd0:    r = 6'd0;
      4'd1:    r = 6'd2;
      4'd2:    r = 6'd8;
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd32;
      4'd5:    r = 6'd34;
      4'd6:    r = 6'd40;
      4'd7:    r = 6'd42;
      4'd8:    r = 6'd0;
      4'd9:    r = 6'd3;
      4'd10:   r = 6'd12;
      4'd11:   r = 6'd15;
      4'd12:   r = 6'd48;
      4'd13:   r = 6'd51;
      4'd14:   r = 6'd60;
      default: r = 6'd63;
    endcase
    return r;
  endfunction

  function automatic color_t pen_basic(input logic [7:0] a);
    return basic_index({a[6], a[2:0]});
  endfunction

  function automatic color_t paper_basic(input logic [7:0] a);
    return basic_index(a[6:3]);
  endfunction

endpackage

[rtl/enhanced_attribute_cell_decoder.sv]
// enhanced_attribute_cell_decoder: top level, port registers and result register
// depends on eacd_pkg, eacd_border, eacd_cell
// result valid rises in the cycle after a cell or border input is taken
// throughput: one item per cycle; input is taken while the result register is
// empty or being drained in the same cycle
// reset clears the border and mode bytes and the result valid flag

module enhanced_attribute_cell_decoder import eacd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] port_address,
  input  logic [7:0]  port_data,
  input  logic [7:0]  pixel_byte,
  input  logic [7:0]  attr_first,
  input  logic [7:0]  attr_second,
  input  logic        flash_phase,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  pix0,
  output logic [5:0]  pix1,
  output logic [5:0]  pix2,
  output logic [5:0]  pix3,
  output logic [5:0]  pix4,
  output logic [5:0]  pix5,
  output logic [5:0]  pix6,
  output logic [5:0]  pix7,
  output logic        is_border
);

  logic [7:0] border_reg;
  logic [7:0] mode_reg;
  logic       result_valid;
  pix_row_t   result_pix;
  logic       result_border;

  logic       in_fire;
  command_t   cmd;
  color_t     border_color;
  pix_row_t   cell_pix;
  pix_row_t   pix_next;
  logic       produce;

  assign in_ready = !result_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cmd      = command_t'(command);

  eacd_border u_border (
    .border_byte (border_reg),
    .mode_byte   (mode_reg),
    .flash_phase (flash_phase),
    .color       (border_color)
  );

  eacd_cell u_cell (
    .mode_byte   (mode_reg),
    .pixel_byte  (pixel_byte),
    .attr_first  (attr_first),
    .attr_second (attr_second),
    .flash_phase (flash_phase),
    .pix         (cell_pix)
  );

  always_comb begin
    produce  = 1'b0;
    pix_next = cell_pix;
    case (cmd)
      CMD_CELL: begin
        produce = 1'b1;
      end
      CMD_BORDER: begin
        produce  = 1'b1;
        pix_next = {8{border_color}};
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      border_reg <= 8'h00;
      mode_reg   <= 8'h00;
    end else if (in_fire && cmd == CMD_PORT_WRITE) begin
      if (!port_address[0]) begin
        border_reg <= port_data;
      end else if (port_address == MODE_PORT_ADDR) begin
        mode_reg <= port_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_ready) begin
      result_valid <= in_fire && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      result_pix    <= pix_next;
      result_border <= (cmd == CMD_BORDER);
    end
  end

  assign out_valid = result_valid;
  assign is_border = result_border;
  assign pix0      = result_pix[0];
  assign pix1      = result_pix[1];
  assign pix2      = result_pix[2];
  assign pix3      = result_pix[3];
  assign pix4      = result_pix[4];
  assign pix5      = result_pix[5];
  assign pix6      = result_pix[6];
  assign pix7      = result_pix[7];

endmodule

[rtl/eacd_border.sv]
// eacd_border: border colour from the border and mode bytes
// depends on eacd_pkg

module eacd_border import eacd_pkg::*; (
  input  logic [7:0] border_byte,
  input  logic [7:0] mode_byte,
  input  logic       flash_phase,
  output color_t     color
);

  always_comb begin
    if (!mode_byte[MODE_EBORDER]) begin
      color = basic_index({1'b0, border_byte[2:0]});
    end else if (mode_byte[MODE_EXTRA]) begin
      // border byte bits rearranged into GRB
      color = {border_byte[2], border_byte[7], border_byte[1],
               border_byte[6], border_byte[0], border_byte[5]};
    end else if (border_byte[7] && flash_phase) begin
      if (border_byte[5]) begin
        color = border_byte[6] ? COLOR_BRIGHT_WHT : COLOR_WHITE;
      end else begin
        color = COLOR_BLACK;
      end
    end else begin
      color = pen_basic(border_byte);
    end
  end

endmodule

[rtl/eacd_cell.sv]
// eacd_cell: screen cell to eight palette indices (attribute modes, flash, half cell)
// depends on eacd_pkg

module eacd_cell import eacd_pkg::*; (
  input  logic [7:0] mode_byte,
  input  logic [7:0] pixel_byte,
  input  logic [7:0] attr_first,
  input  logic [7:0] attr_second,
  input  logic       flash_phase,
  output pix_row_t   pix
);

  logic [7:0] bits;
  color_t     lset;
  color_t     lclr;
  color_t     rset;
  color_t     rclr;
  color_t     c1;
  color_t     c2;
  logic       half;

  assign half = mode_byte[MODE_HALF];

  always_comb begin
    bits = pixel_byte;
    c1   = pen_basic(attr_first);
    c2   = paper_basic(attr_first);
    lset = c1;
    lclr = c2;
    rset = c1;
    rclr = c2;
    if (mode_byte[MODE_DOUBLE]) begin
      if (flash_phase) begin
        if (attr_first[7]) begin
          bits = attr_second[7] ? ~pixel_byte : 8'h00;
        end else if (attr_second[7]) begin
          bits = 8'hFF;
        end
      end
      if (mode_byte[MODE_EXTRA]) begin
        c1 = attr_first[5:0];
        c2 = attr_second[5:0];
        if (half) begin
          lset = c2;
          lclr = COLOR_BLACK;
          rset = c1;
          rclr = COLOR_BLACK;
        end else begin
          lset = c1;
          lclr = c2;
          rset = c1;
          rclr = c2;
        end
      end else begin
        c1 = pen_basic(attr_first);
        c2 = pen_basic(attr_second);
        rset = c1;
        rclr = c2;
        if (half) begin
          lset = paper_basic(attr_first);
          lclr = paper_basic(attr_second);
        end else begin
          lset = c1;
          lclr = c2;
        end
      end
    end else begin
      if (attr_first[7] && flash_phase) begin
        bits = ~pixel_byte;
      end
      if (mode_byte[MODE_EXTRA]) begin
        c1 = attr_first[5:0];
        c2 = attr_first[6] ? COLOR_WHITE : COLOR_BLACK;
      end
      if (half) begin
        lset = c2;
        lclr = COLOR_BLACK;
        rset = c1;
        rclr = COLOR_BLACK;
      end else begin
        lset = c1;
        lclr = c2;
        rset = c1;
        rclr = c2;
      end
    end
  end

  // msb pixel first
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (i < 4) begin
        pix[i] = bits[7 - i] ? lset : lclr;
      end else begin
        pix[i] = bits[7 - i] ? rset : rclr;
      end
    end
  end

endmodule

[bench/enhanced_attribute_cell_decoder_tb.sv]
// enhanced_attribute_cell_decoder_tb: self-checking bench for the attribute cell decoder
// predicts each cell and border group from its own copy of the border and mode bytes
// depends on eacd_pkg and enhanced_attribute_cell_decoder

module enhanced_attribute_cell_decoder_tb;
  import eacd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 4;

  // basic palette, entry 15 first
  localparam logic [16*6-1:0] PALETTE_BITS = {
    6'd63, 6'd60, 6'd51, 6'd48, 6'd15, 6'd12, 6'd3, 6'd0,
    6'd42, 6'd40, 6'd34, 6'd32, 6'd10, 6'd8, 6'd2, 6'd0
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] port_address;
    logic [7:0]  port_data;
    logic [7:0]  pixel_byte;
    logic [7:0]  attr_first;
    logic [7:0]  attr_second;
    logic        flash_phase;
  } video_item_t;

  typedef struct packed {
    pix_row_t pixels;
    logic     border;
  } pixel_group_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, is_border;
  logic [5:0] pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7;

  video_item_t bus_item = '0;
  video_item_t pending_items[$];
  pixel_group_t expected_groups[$];
  pixel_group_t predicted, got_group, want_group;

  logic [7:0] border_byte = 8'h00;
  logic [7:0] mode_byte = 8'h00;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  enhanced_attribute_cell_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(bus_item.command), .port_address(bus_item.port_address),
    .port_data(bus_item.port_data), .pixel_byte(bus_item.pixel_byte),
    .attr_first(bus_item.attr_first), .attr_second(bus_item.attr_second),
    .flash_phase(bus_item.flash_phase),
    .out_valid(out_valid), .out_ready(out_ready),
    .pix0(pix0), .pix1(pix1), .pix2(pix2), .pix3(pix3),
    .pix4(pix4), .pix5(pix5), .pix6(pix6), .pix7(pix7),
    .is_border(is_border)
  );

  function automatic color_t basic_color(input logic [3:0] c);
    return PALETTE_BITS[c*6 +: 6];
  endfunction

  function automatic color_t ink_color(input logic [7:0] a);
    return basic_color({a[6], a[2:0]});
  endfunction

  function automatic color_t paper_color(input logic [7:0] a);
    return basic_color(a[6:3]);
  endfunction

  function automatic color_t border_color(input logic flash);
    color_t c;
    if (!mode_byte[MODE_EBORDER]) begin
      c = basic_color({1'b0, border_byte[2:0]});
    end else if (mode_byte[MODE_EXTRA]) begin
      // border byte bits reshuffled straight into GRB
      c = {border_byte[2], border_byte[7], border_byte[1],
           border_byte[6], border_byte[0], border_byte[5]};
    end else if (border_byte[7] && flash) begin
      if (border_byte[5])
        c = border_byte[6] ? COLOR_BRIGHT_WHT : COLOR_WHITE;
      else
        c = COLOR_BLACK;
    end else begin
      c = ink_color(border_byte);
    end
    return c;
  endfunction

  // updates the border and mode copies, returns 1 when a pixel group follows
  function automatic logic decode_item(input video_item_t it, output pixel_group_t grp);
    logic produced;
    logic [7:0] bits;
    color_t c1, c2, lset, lclr, rset, rclr;
    produced = 1'b0;
    grp = '0;
    case (it.command)
      CMD_PORT_WRITE: begin
        if (!it.port_address[0])
          border_byte = it.port_data;
        else if (it.port_address == MODE_PORT_ADDR)
          mode_byte = it.port_data;
      end
      CMD_BORDER: begin
        c1 = border_color(it.flash_phase);
        for (int i = 0; i < 8; i++) grp.pixels[i] = c1;
        grp.border = 1'b1;
        produced = 1'b1;
      end
      CMD_CELL: begin
        bits = it.pixel_byte;
        if (mode_byte[MODE_DOUBLE]) begin
          if (it.flash_phase) begin
            if (it.attr_first[7])
              bits = it.attr_second[7] ? ~bits : 8'h00;
            else if (it.attr_second[7])
              bits = 8'hFF;
          end
          if (mode_byte[MODE_EXTRA]) begin
            c1 = it.attr_first[5:0];
            c2 = it.attr_second[5:0];
            if (mode_byte[MODE_HALF]) begin
              lset = c2; lclr = COLOR_BLACK; rset = c1; rclr = COLOR_BLACK;
            end else begin
              lset = c1; lclr = c2; rset = c1; rclr = c2;
            end
          end else begin
            c1 = ink_color(it.attr_first);
            c2 = ink_color(it.attr_second);
            if (mode_byte[MODE_HALF]) begin
              lset = paper_color(it.attr_first);
              lclr = paper_color(it.attr_second);
              rset = c1; rclr = c2;
            end else begin
              lset = c1; lclr = c2; rset = c1; rclr = c2;
            end
          end
        end else begin
          if (it.attr_first[7] && it.flash_phase) bits = ~bits;
          if (mode_byte[MODE_EXTRA]) begin
            c1 = it.attr_first[5:0];
            c2 = it.attr_first[6] ? basic_color(4'd7) : COLOR_BLACK;
          end else begin
            c1 = ink_color(it.attr_first);
            c2 = paper_color(it.attr_first);
          end
          if (mode_byte[MODE_HALF]) begin
            lset = c2; lclr = COLOR_BLACK; rset = c1; rclr = COLOR_BLACK;
          end else begin
            lset = c1; lclr = c2; rset = c1; rclr = c2;
          end
        end
        for (int i = 0; i < 8; i++) begin
          if (i < 4) grp.pixels[i] = bits[7-i] ? lset : lclr;
          else grp.pixels[i] = bits[7-i] ? rset : rclr;
        end
        grp.border = 1'b0;
        produced = 1'b1;
      end
      default: produced = 1'b0;
    endcase
    return produced;
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic queue_item(input logic [1:0] cmd, input logic [15:0] addr,
                            input logic [7:0] data, input logic [7:0] pix,
                            input logic [7:0] a1, input logic [7:0] a2, input logic flash);
    video_item_t it;
    it.command = cmd;
    it.port_address = addr;
    it.port_data = data;
    it.pixel_byte = pix;
    it.attr_first = a1;
    it.attr_second = a2;
    it.flash_phase = flash;
    pending_items.push_back(it);
  endtask

  // mostly cells and border groups, with register writes and some ignored noise
  task automatic queue_random();
    int pick;
    logic [1:0] cmd;
    logic [15:0] addr;
    pick = $urandom_range(99);
    addr = 16'($urandom);
    if (pick < 38) begin
      cmd = CMD_CELL;
    end else if (pick < 62) begin
      cmd = CMD_BORDER;
    end else if (pick < 76) begin
      cmd = CMD_PORT_WRITE;
      addr[0] = 1'b0;
    end else if (pick < 86) begin
      cmd = CMD_PORT_WRITE;
      addr = MODE_PORT_ADDR;
    end else if (pick < 93) begin
      cmd = CMD_PORT_WRITE;
      addr[0] = 1'b1;
      if (addr == MODE_PORT_ADDR) addr[1] = 1'b0;
    end else begin
      cmd = CMD_UNUSED;
    end
    queue_item(cmd, addr, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_groups.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct <= idle_pct;
    recv_stall_pct <= stall_pct;
    for (int k = 0; k < n; k++) queue_random();
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (decode_item(bus_item, predicted)) expected_groups.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got_group.pixels = {pix7, pix6, pix5, pix4, pix3, pix2, pix1, pix0};
        got_group.border = is_border;
        if (expected_groups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: border %0d pix0 %0d", is_border, pix0);
        end else begin
          want_group = expected_groups.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got_group.pixels[i] !== want_group.pixels[i])
              note_mismatch($sformatf("pix%0d", i), want_group.pixels[i], got_group.pixels[i]);
          end
          if (got_group.border !== want_group.border)
            note_mismatch("is_border", want_group.border, got_group.border);
        end
      end
      if (hold_requests != holds_served) begin
        holds_served <= holds_served + 1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("enhanced_attribute_cell_decoder verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset state, flash inversion, a border write, ignored writes and the unused command
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'hA5, 8'hFF, 8'h00, 1'b1);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'h0F, 8'h7F, 8'hFF, 1'b0);
    queue_item(CMD_PORT_WRITE, 16'hFFFE, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_item(CMD_PORT_WRITE, 16'hFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_item(CMD_PORT_WRITE, 16'h7FDD, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_UNUSED, MODE_PORT_ADDR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    // enhanced border, basic colours: flash white, bright white, black
    queue_item(CMD_PORT_WRITE, MODE_PORT_ADDR, 8'h10, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_item(CMD_PORT_WRITE, 16'h0000, 8'hA0, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_PORT_WRITE, 16'h0002, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    // enhanced border with extra colours
    queue_item(CMD_PORT_WRITE, MODE_PORT_ADDR, 8'h14, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_PORT_WRITE, 16'h8000, 8'hE7, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    // extra colours in single and half modes, then a basic half cell
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'h3C, 8'hFF, 8'h00, 1'b1);
    queue_item(CMD_PORT_WRITE, MODE_PORT_ADDR, 8'h84, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'h96, 8'h5A, 8'h00, 1'b0);
    queue_item(CMD_PORT_WRITE, MODE_PORT_ADDR, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'h96, 8'hC5, 8'h00, 1'b1);
    // double-byte flash combinations
    queue_item(CMD_PORT_WRITE, MODE_PORT_ADDR, 8'h08, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'h5A, 8'h83, 8'hC4, 1'b1);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'h5A, 8'h83, 8'h44, 1'b1);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'h5A, 8'h03, 8'hC4, 1'b1);
    queue_item(CMD_PORT_WRITE, MODE_PORT_ADDR, 8'h8C, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'hC3, 8'h2D, 8'h12, 1'b0);
    queue_item(CMD_PORT_WRITE, MODE_PORT_ADDR, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_item(CMD_CELL, 16'h0000, 8'h00, 8'hF0, 8'hFF, 8'hFF, 1'b1);
    queue_item(CMD_BORDER, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    wait_drained();

    run_phase(0, 0, 340);
    run_phase(60, 0, 340);
    run_phase(0, 60, 340);
    run_phase(27, 27, 340);

    // receiver holds off while the sender keeps offering
    hold_requests <= hold_requests + 1;
    run_phase(0, 0, 340);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_groups.size() != 0) mismatches += expected_groups.size();
    if (mismatches == 0)
      $display("enhanced_attribute_cell_decoder verification clean");
    else
      $display("enhanced_attribute_cell_decoder verification failed");
    $finish;
  end

endmodule
